// ===== hw/rtl/cme_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cme_pkg
// Shared types, codes and Q.32 helper functions of the central moments engine.
// ----------------------------------------------------------------------------
package cme_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int          CFG_IDX_BITS  = 8;
  localparam logic [CFG_IDX_BITS-1:0] REG_PDF_MODE  = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_POS_RANGE = 8'd1;
  localparam logic [31:0] RANGE_RESET   = 32'h0001_0000;

  // moment select
  localparam logic [1:0] MSEL_TWO   = 2'd0;
  localparam logic [1:0] MSEL_THREE = 2'd1;
  localparam logic [1:0] MSEL_FOUR  = 2'd2;

  // divider dividend shift
  localparam logic [1:0] SH_ZERO = 2'd0;
  localparam logic [1:0] SH_ONE  = 2'd1;
  localparam logic [1:0] SH_Q32  = 2'd2;

  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD_SAMPLE,
    OP_DIV_MEAN,
    OP_DIV_Q0,
    OP_DIV_C,
    OP_DIV_M,
    OP_WR_C,
    OP_WR_Q0,
    OP_INIT_LOOP,
    OP_RD,
    OP_LDX,
    OP_SUB,
    OP_NEXT,
    OP_MUL_POSX,
    OP_MUL_DD,
    OP_MUL_D2X,
    OP_MUL_TD,
    OP_MUL_TD2,
    OP_MUL_MR,
    OP_ACC_NUM,
    OP_WR_D2,
    OP_WR_T,
    OP_ACC_M2,
    OP_ACC_M3,
    OP_ACC_M4,
    OP_WR_M,
    OP_WR_MR,
    OP_LOAD_OK,
    OP_LOAD_ERR,
    OP_LOAD_ZERO
  } cme_op_t;

  typedef struct packed {
    cme_op_t    op;
    logic [1:0] msel;
  } cme_cmd_t;

  typedef struct packed {
    logic lt2;
    logic pdf;
    logic wzero;
    logic last_elem;
    logic mul_done;
    logic div_done;
    logic out_free;
  } cme_stat_t;

  function automatic logic [63:0] sat65(input logic [64:0] v);
    logic [63:0] r;
    if (v[64] != v[63]) r = v[64] ? S64_MIN : S64_MAX;
    else r = v[63:0];
    return r;
  endfunction

  function automatic logic [63:0] sadd(input logic [63:0] a, input logic [63:0] b);
    return sat65({a[63], a} + {b[63], b});
  endfunction

  function automatic logic [63:0] ssub(input logic [63:0] a, input logic [63:0] b);
    return sat65({a[63], a} - {b[63], b});
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic [63:0] from_mag(input logic [63:0] m, input logic neg);
    logic [63:0] r;
    if (neg) r = m[63] ? S64_MIN : (64'd0 - m);
    else r = m[63] ? S64_MAX : m;
    return r;
  endfunction

  // quotient carries one extra fraction bit: round half away from zero
  function automatic logic [63:0] div_round(input logic [63:0] q, input logic ovf,
                                            input logic neg);
    logic [63:0] m;
    m = ovf ? '1 : ((q >> 1) + {63'd0, q[0]});
    return from_mag(m, neg);
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/cme_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cme_mul
// Sequential Q.32 multiplier: four 32x32 partial products, rounded, saturated.
// ----------------------------------------------------------------------------
module cme_mul
  import cme_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  output logic             done,
  output logic [63:0]      res
);

  logic [63:0]  am_r, bm_r;
  logic         neg_r;
  logic [127:0] acc_r;
  logic [2:0]   step_r;
  logic         busy_r;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0]  mag;

  always_comb begin
    pa = step_r[1] ? am_r[63:32] : am_r[31:0];
    pb = step_r[0] ? bm_r[63:32] : bm_r[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
    unique case (step_r[1:0])
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    mag = (acc_r[127:96] != 32'd0) ? '1 : acc_r[95:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      step_r <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        am_r   <= mag64(a);
        bm_r   <= mag64(b);
        neg_r  <= a[63] ^ b[63];
        acc_r  <= 128'd1 << 31;
        step_r <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (step_r != 3'd4) begin
          acc_r  <= acc_r + pp_sh;
          step_r <= step_r + 3'd1;
        end else begin
          res    <= from_mag(mag, neg_r);
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cme_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cme_div
// Restoring divider, one quotient bit per cycle over a 97-bit dividend.
// ----------------------------------------------------------------------------
module cme_div
  import cme_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] a_mag,
  input  wire logic [63:0] b_mag,
  input  wire logic [1:0]  sh,
  output logic             done,
  output logic [63:0]      quo,
  output logic [63:0]      rem,
  output logic             ovf
);

  localparam int DW = 97;

  logic [DW-1:0] d_r;
  logic [63:0]   b_r;
  logic [6:0]    cnt_r;
  logic          busy_r;
  logic [64:0]   r65;
  logic          ge;
  logic [DW-1:0] dvd;

  always_comb begin
    unique case (sh)
      SH_ONE:  dvd = {32'd0, a_mag, 1'b0};
      SH_Q32:  dvd = {a_mag, 33'd0};
      default: dvd = {33'd0, a_mag};
    endcase
    r65 = {rem, d_r[DW-1]};
    ge  = (r65 >= {1'b0, b_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        d_r    <= dvd;
        b_r    <= b_mag;
        rem    <= '0;
        quo    <= '0;
        ovf    <= 1'b0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        d_r <= {d_r[DW-2:0], 1'b0};
        ovf <= ovf | quo[63];
        quo <= {quo[62:0], ge};
        rem <= ge ? 64'(r65 - {1'b0, b_r}) : r65[63:0];
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == 7'(DW - 1)) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cme_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cme_datapath
// Frame buffer, working registers, config registers and result register.
// ----------------------------------------------------------------------------
module cme_datapath
  import cme_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cme_cmd_t                     cmd,
  output cme_stat_t                         stat,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  wire logic                         cfg_valid,
  input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [31:0]                  cfg_data,
  input  wire logic                         out_stall,
  output logic                              out_valid,
  output logic                              out_status,
  output logic                              out_moment_zero,
  output logic signed [63:0]                out_moment_two,
  output logic signed [63:0]                out_moment_three,
  output logic signed [63:0]                out_moment_four
);

  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int XSH = 33 - SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0] mem [MAX_SAMPLES];
  logic [SAMPLE_BITS-1:0] rdata_r;

  logic [CW-1:0] cnt_r;
  logic [63:0]   sum_r;
  logic          pdf_mode_r;
  logic [31:0]   range_r;

  logic [AW-1:0] idx_r;
  logic [63:0]   pos_q_r;
  logic [CW-1:0] pos_rem_r;
  logic [63:0]   q0_r;
  logic [CW-1:0] r0_r;
  logic [63:0]   x_r, pos_val_r, c_r, d_r, d2_r, t_r, num_r, m2_r, m3_r, m4_r;
  logic          div_neg_r;

  logic [63:0]   x_in, x_mem, nm1, msel_val, r32;
  logic          mul_start, div_start, mul_done, div_done, div_ovf;
  logic [63:0]   mul_a, mul_b, mul_res, div_a, div_b, div_q, div_rem, div_res;
  logic [1:0]    div_sh;
  logic [CW:0]   rem_sum;
  logic          pos_rnd;

  always_comb begin
    x_in  = {{(64-SAMPLE_BITS){in_sample_value[SAMPLE_BITS-1]}}, in_sample_value} << XSH;
    x_mem = {{(64-SAMPLE_BITS){rdata_r[SAMPLE_BITS-1]}}, rdata_r} << XSH;
    nm1   = {{(64-CW){1'b0}}, cnt_r - CW'(1)};
    r32   = {16'd0, range_r, 16'd0};
    unique case (cmd.msel)
      MSEL_THREE: msel_val = m3_r;
      MSEL_FOUR:  msel_val = m4_r;
      default:    msel_val = m2_r;
    endcase
    rem_sum = {1'b0, pos_rem_r} + {1'b0, r0_r};
    pos_rnd = ({pos_rem_r, 1'b0} >= {1'b0, nm1[CW-1:0]});
    div_res = div_round(div_q, div_ovf, div_neg_r);

    mul_start = 1'b1;
    mul_a     = d_r;
    mul_b     = d_r;
    unique case (cmd.op)
      OP_MUL_POSX: begin mul_a = pos_val_r; mul_b = x_r;  end
      OP_MUL_DD:   begin mul_a = d_r;       mul_b = d_r;  end
      OP_MUL_D2X:  begin mul_a = d2_r;      mul_b = x_r;  end
      OP_MUL_TD:   begin mul_a = t_r;       mul_b = d_r;  end
      OP_MUL_TD2:  begin mul_a = t_r;       mul_b = d2_r; end
      OP_MUL_MR:   begin mul_a = msel_val;  mul_b = r32;  end
      default:     mul_start = 1'b0;
    endcase

    div_start = 1'b1;
    div_a     = sum_r;
    div_b     = {{(64-CW){1'b0}}, cnt_r};
    div_sh    = SH_ONE;
    unique case (cmd.op)
      OP_DIV_MEAN: begin
        div_a = sum_r; div_b = {{(64-CW){1'b0}}, cnt_r}; div_sh = SH_ONE;
      end
      OP_DIV_Q0: begin
        div_a = 64'h1_0000_0000; div_b = nm1; div_sh = SH_ZERO;
      end
      OP_DIV_C: begin
        div_a = num_r; div_b = sum_r; div_sh = SH_Q32;
      end
      OP_DIV_M: begin
        div_a  = msel_val;
        div_b  = pdf_mode_r ? sum_r : {{(64-CW){1'b0}}, cnt_r};
        div_sh = pdf_mode_r ? SH_Q32 : SH_ONE;
      end
      default: div_start = 1'b0;
    endcase
  end

  cme_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  cme_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a_mag (mag64(div_a)),
    .b_mag (mag64(div_b)),
    .sh    (div_sh),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_rem),
    .ovf   (div_ovf)
  );

  always_comb begin
    stat.lt2       = (cnt_r < CW'(2));
    stat.pdf       = pdf_mode_r;
    stat.wzero     = (sum_r == 64'd0);
    stat.last_elem = (CW'(idx_r) == (cnt_r - CW'(1)));
    stat.mul_done  = mul_done;
    stat.div_done  = div_done;
    stat.out_free  = !out_valid || !out_stall;
  end

  // frame buffer
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD_SAMPLE && cnt_r < CW'(MAX_SAMPLES))
      mem[cnt_r[AW-1:0]] <= in_sample_value;
    if (cmd.op == OP_RD)
      rdata_r <= mem[idx_r];
  end

  // control state: frame count, sum, config, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      sum_r      <= '0;
      pdf_mode_r <= 1'b0;
      range_r    <= RANGE_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_PDF_MODE) pdf_mode_r <= cfg_data[0];
        else if (cfg_index == REG_POS_RANGE) range_r <= cfg_data;
      end
      if (cmd.op == OP_LOAD_SAMPLE && cnt_r < CW'(MAX_SAMPLES)) begin
        cnt_r <= cnt_r + CW'(1);
        sum_r <= sadd(sum_r, x_in);
      end
      if (cmd.op == OP_LOAD_OK || cmd.op == OP_LOAD_ERR || cmd.op == OP_LOAD_ZERO) begin
        cnt_r     <= '0;
        sum_r     <= '0;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (div_start) div_neg_r <= div_a[63] ^ div_b[63];
    unique case (cmd.op)
      OP_WR_C:  c_r <= div_res;
      OP_WR_Q0: begin
        q0_r <= div_q;
        r0_r <= div_rem[CW-1:0];
      end
      OP_INIT_LOOP: begin
        idx_r     <= '0;
        pos_q_r   <= '0;
        pos_rem_r <= '0;
        num_r     <= '0;
        m2_r      <= '0;
        m3_r      <= '0;
        m4_r      <= '0;
      end
      OP_LDX: begin
        x_r       <= x_mem;
        pos_val_r <= pos_q_r + {63'd0, pos_rnd};
      end
      OP_SUB:   d_r <= ssub(pdf_mode_r ? pos_val_r : x_r, c_r);
      OP_NEXT: begin
        idx_r <= idx_r + AW'(1);
        // running quotient and remainder of i * 2^32 / (n-1)
        if (rem_sum >= {1'b0, nm1[CW-1:0]}) begin
          pos_rem_r <= CW'(rem_sum - {1'b0, nm1[CW-1:0]});
          pos_q_r   <= pos_q_r + q0_r + 64'd1;
        end else begin
          pos_rem_r <= rem_sum[CW-1:0];
          pos_q_r   <= pos_q_r + q0_r;
        end
      end
      OP_ACC_NUM: num_r <= sadd(num_r, mul_res);
      OP_WR_D2: begin
        d2_r <= mul_res;
        t_r  <= mul_res;
      end
      OP_WR_T:   t_r  <= mul_res;
      OP_ACC_M2: m2_r <= sadd(m2_r, t_r);
      OP_ACC_M3: m3_r <= sadd(m3_r, mul_res);
      OP_ACC_M4: m4_r <= sadd(m4_r, mul_res);
      OP_WR_M, OP_WR_MR: begin
        unique case (cmd.msel)
          MSEL_THREE: m3_r <= (cmd.op == OP_WR_M) ? div_res : mul_res;
          MSEL_FOUR:  m4_r <= (cmd.op == OP_WR_M) ? div_res : mul_res;
          default:    m2_r <= (cmd.op == OP_WR_M) ? div_res : mul_res;
        endcase
      end
      OP_LOAD_OK: begin
        out_status       <= 1'b0;
        out_moment_zero  <= 1'b1;
        out_moment_two   <= m2_r;
        out_moment_three <= m3_r;
        out_moment_four  <= m4_r;
      end
      OP_LOAD_ERR, OP_LOAD_ZERO: begin
        out_status       <= (cmd.op == OP_LOAD_ERR);
        out_moment_zero  <= 1'b0;
        out_moment_two   <= '0;
        out_moment_three <= '0;
        out_moment_four  <= '0;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hw/rtl/cme_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cme_ctrl
// Sequencer: frame loading, buffer passes (two in pdf mode) and final scaling.
// ----------------------------------------------------------------------------
module cme_ctrl
  import cme_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_last_sample,
  output logic           in_stall,
  input  wire cme_stat_t stat,
  output cme_cmd_t       cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_MEAN_W, S_Q0_W, S_INIT1,
    S_L1_RD, S_L1_LD, S_L1_MUL, S_L1_W, S_L1_NX,
    S_C_DIV, S_C_W, S_INIT2,
    S_L2_RD, S_L2_LD, S_L2_SUB, S_L2_M1, S_L2_W1, S_L2_M2, S_L2_W2,
    S_L2_ACC, S_L2_M3, S_L2_W3, S_L2_M4, S_L2_W4, S_L2_NX,
    S_F_DIV, S_F_DW, S_F_MUL, S_F_MW, S_OUT
  } state_t;

  typedef enum logic [1:0] {K_OK, K_ERR, K_ZERO} kind_t;

  state_t     state_r, state_nxt;
  kind_t      kind_r, kind_nxt;
  logic [1:0] msel_r, msel_nxt;
  logic [2:0] rep_r, rep_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    msel_nxt  = msel_r;
    rep_nxt   = rep_r;
    cmd.msel  = msel_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op = OP_LOAD_SAMPLE;
        if (in_last_sample) state_nxt = S_START;
      end
      S_START: begin
        kind_nxt = K_OK;
        if (stat.lt2) begin
          kind_nxt = K_ERR; state_nxt = S_OUT;
        end else if (stat.pdf && stat.wzero) begin
          kind_nxt = K_ZERO; state_nxt = S_OUT;
        end else if (stat.pdf) begin
          cmd.op = OP_DIV_Q0; state_nxt = S_Q0_W;
        end else begin
          cmd.op = OP_DIV_MEAN; state_nxt = S_MEAN_W;
        end
      end
      S_MEAN_W: if (stat.div_done) begin
        cmd.op = OP_WR_C; state_nxt = S_INIT2;
      end
      S_Q0_W: if (stat.div_done) begin
        cmd.op = OP_WR_Q0; state_nxt = S_INIT1;
      end
      S_INIT1: begin cmd.op = OP_INIT_LOOP; state_nxt = S_L1_RD; end
      S_L1_RD: begin cmd.op = OP_RD;        state_nxt = S_L1_LD; end
      S_L1_LD: begin cmd.op = OP_LDX;       state_nxt = S_L1_MUL; end
      S_L1_MUL: begin cmd.op = OP_MUL_POSX; state_nxt = S_L1_W; end
      S_L1_W: if (stat.mul_done) begin
        cmd.op = OP_ACC_NUM; state_nxt = S_L1_NX;
      end
      S_L1_NX: begin
        if (stat.last_elem) state_nxt = S_C_DIV;
        else begin cmd.op = OP_NEXT; state_nxt = S_L1_RD; end
      end
      S_C_DIV: begin cmd.op = OP_DIV_C; state_nxt = S_C_W; end
      S_C_W: if (stat.div_done) begin
        cmd.op = OP_WR_C; state_nxt = S_INIT2;
      end
      // INIT_LOOP restarts the position sequence at zero, stepping by q0 kept in the datapath
      S_INIT2:  begin cmd.op = OP_INIT_LOOP; state_nxt = S_L2_RD; end
      S_L2_RD:  begin cmd.op = OP_RD;        state_nxt = S_L2_LD; end
      S_L2_LD:  begin cmd.op = OP_LDX;       state_nxt = S_L2_SUB; end
      S_L2_SUB: begin cmd.op = OP_SUB;       state_nxt = S_L2_M1; end
      S_L2_M1:  begin cmd.op = OP_MUL_DD;    state_nxt = S_L2_W1; end
      S_L2_W1: if (stat.mul_done) begin
        cmd.op    = OP_WR_D2;
        state_nxt = stat.pdf ? S_L2_M2 : S_L2_ACC;
      end
      S_L2_M2: begin cmd.op = OP_MUL_D2X; state_nxt = S_L2_W2; end
      S_L2_W2: if (stat.mul_done) begin
        cmd.op = OP_WR_T; state_nxt = S_L2_ACC;
      end
      S_L2_ACC: begin cmd.op = OP_ACC_M2; state_nxt = S_L2_M3; end
      S_L2_M3:  begin cmd.op = OP_MUL_TD; state_nxt = S_L2_W3; end
      S_L2_W3: if (stat.mul_done) begin
        cmd.op = OP_ACC_M3; state_nxt = S_L2_M4;
      end
      S_L2_M4: begin cmd.op = OP_MUL_TD2; state_nxt = S_L2_W4; end
      S_L2_W4: if (stat.mul_done) begin
        cmd.op = OP_ACC_M4; state_nxt = S_L2_NX;
      end
      S_L2_NX: begin
        if (stat.last_elem) begin
          msel_nxt = MSEL_TWO; state_nxt = S_F_DIV;
        end else begin
          cmd.op = OP_NEXT; state_nxt = S_L2_RD;
        end
      end
      S_F_DIV: begin cmd.op = OP_DIV_M; state_nxt = S_F_DW; end
      S_F_DW: if (stat.div_done) begin
        cmd.op = OP_WR_M;
        if (stat.pdf) begin
          // order k moment takes k range multiplies
          rep_nxt   = 3'({1'b0, msel_r} + 3'd2);
          state_nxt = S_F_MUL;
        end else if (msel_r == MSEL_FOUR) begin
          state_nxt = S_OUT;
        end else begin
          msel_nxt = msel_r + 2'd1; state_nxt = S_F_DIV;
        end
      end
      S_F_MUL: begin cmd.op = OP_MUL_MR; state_nxt = S_F_MW; end
      S_F_MW: if (stat.mul_done) begin
        cmd.op  = OP_WR_MR;
        rep_nxt = rep_r - 3'd1;
        if (rep_r != 3'd1) state_nxt = S_F_MUL;
        else if (msel_r == MSEL_FOUR) state_nxt = S_OUT;
        else begin
          msel_nxt = msel_r + 2'd1; state_nxt = S_F_DIV;
        end
      end
      S_OUT: if (stat.out_free) begin
        unique case (kind_r)
          K_ERR:   cmd.op = OP_LOAD_ERR;
          K_ZERO:  cmd.op = OP_LOAD_ZERO;
          default: cmd.op = OP_LOAD_OK;
        endcase
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= K_OK;
      msel_r  <= MSEL_TWO;
      rep_r   <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      msel_r  <= msel_nxt;
      rep_r   <= rep_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/central_moments_engine_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// central_moments_engine_top
// 2nd, 3rd and 4th central moments of a sample frame, sample or pdf mode.
// ----------------------------------------------------------------------------
// Samples load at one per cycle into the frame buffer while the engine is
// idle; the transfer with in_last_sample set closes the frame and input
// stalls until the result is placed in the output register. Every multiply
// runs on the single shared 32x32 partial-product multiplier and every
// divide on the shared bit-serial divider (4 divides in sample mode, 5 in
// pdf mode). A short frame or a zero weight sum skips the passes and goes
// straight to the output. The result register lets the next frame load
// while a result waits. Config writes are taken at any time but belong
// between frames; the registers are read while a closed frame is processed.
module central_moments_engine_top
  import cme_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0] in_sample_value,
  input  wire logic                          in_last_sample,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_status,
  output logic                               out_moment_zero,
  output logic signed [63:0]                 out_moment_two,
  output logic signed [63:0]                 out_moment_three,
  output logic signed [63:0]                 out_moment_four,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
  input  wire logic [31:0]                   cfg_data
);

  cme_cmd_t  cmd;
  cme_stat_t stat;

  assign cfg_ready = 1'b1;

  cme_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_last_sample (in_last_sample),
    .in_stall       (in_stall),
    .stat           (stat),
    .cmd            (cmd)
  );

  cme_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_sample_value  (in_sample_value),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_moment_zero  (out_moment_zero),
    .out_moment_two   (out_moment_two),
    .out_moment_three (out_moment_three),
    .out_moment_four  (out_moment_four)
  );

endmodule
`default_nettype wire

// ===== tb/sv/tb_central_moments_engine_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_central_moments_engine_top
// Self-checking bench for the central moments engine: directed frames (short,
// extremes, zero weight) then random frames under three idle profiles, each
// result checked against a bit-exact Q.32 predictor.
// ----------------------------------------------------------------------------
module tb_central_moments_engine_top;
  import cme_pkg::*;

  localparam int DEPTH     = 1024;
  localparam int WD_LIMIT  = 400000;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 8'hFF;
  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic              status;
    logic              moment_zero;
    logic signed [63:0] m2;
    logic signed [63:0] m3;
    logic signed [63:0] m4;
  } moments_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_sample_value = '0;
  logic in_last_sample = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_status, out_moment_zero;
  logic signed [63:0] out_moment_two, out_moment_three, out_moment_four;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  central_moments_engine_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_sample_value(in_sample_value), .in_last_sample(in_last_sample),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_moment_zero(out_moment_zero),
    .out_moment_two(out_moment_two), .out_moment_three(out_moment_three),
    .out_moment_four(out_moment_four),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [15:0] frame_store [DEPTH];
  int unsigned        frame_len = 0;
  logic signed [63:0] frame_sum = '0;
  logic               cfg_pdf = 1'b0;
  logic [31:0]        cfg_range = RANGE_RESET;

  moments_t expected_moments [$];
  int errors = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int idle_count = 0;

  // ---------------- Q.32 arithmetic ----------------
  function automatic logic signed [63:0] q_add(logic signed [63:0] a, logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] q_sub(logic signed [63:0] a, logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? Q_MIN : Q_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] q_abs(logic signed [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic signed [63:0] q_sign(logic [63:0] m, logic neg);
    if (neg) return m[63] ? Q_MIN : (64'd0 - m);
    return m[63] ? Q_MAX : m;
  endfunction

  function automatic logic signed [63:0] q_mul(logic signed [63:0] a, logic signed [63:0] b);
    logic [127:0] p;
    logic [63:0] m;
    p = {64'd0, q_abs(a)} * {64'd0, q_abs(b)};
    p = p + 128'h8000_0000;
    m = (p[127:96] != 32'd0) ? '1 : p[95:32];
    return q_sign(m, a[63] ^ b[63]);
  endfunction

  // round(a * 2^32 / b), quotient carries one extra rounding bit
  function automatic logic signed [63:0] q_div(logic signed [63:0] a, logic signed [63:0] b);
    logic [127:0] num, qf;
    logic [63:0] ub, m;
    ub = q_abs(b);
    if (ub == 64'd0) return '0;
    num = {31'd0, q_abs(a), 33'd0};
    qf = num / {64'd0, ub};
    m = (qf[127:64] != 64'd0) ? '1 : ((qf[63:0] >> 1) + {63'd0, qf[0]});
    return q_sign(m, a[63] ^ b[63]);
  endfunction

  function automatic logic signed [63:0] int_div(logic signed [63:0] a, logic [63:0] b);
    logic [63:0] m, q, rem;
    m = q_abs(a);
    q = m / b;
    rem = m % b;
    if (rem >= b - rem) q = q + 64'd1;
    return q_sign(q, a[63]);
  endfunction

  function automatic logic signed [63:0] to_q32(logic signed [15:0] s);
    return {{31{s[15]}}, s, 17'd0};
  endfunction

  function automatic moments_t close_frame();
    moments_t r;
    int unsigned n, i;
    logic signed [63:0] m2, m3, m4, mean, d, d2, w, num, c, pos, v, v2, t, r32;
    r = '0;
    m2 = '0; m3 = '0; m4 = '0; num = '0;
    n = frame_len;
    if (n < 2) begin
      r.status = 1'b1;
      return r;
    end
    if (!cfg_pdf) begin
      mean = int_div(frame_sum, 64'(n));
      for (i = 0; i < n; i++) begin
        d = q_sub(to_q32(frame_store[i]), mean);
        d2 = q_mul(d, d);
        m2 = q_add(m2, d2);
        m3 = q_add(m3, q_mul(d2, d));
        m4 = q_add(m4, q_mul(d2, d2));
      end
      m2 = int_div(m2, 64'(n));
      m3 = int_div(m3, 64'(n));
      m4 = int_div(m4, 64'(n));
    end else begin
      w = frame_sum;
      if (w == 0) return r;
      for (i = 0; i < n; i++) begin
        pos = int_div({32'd0, i} << 32, 64'(n - 1));
        num = q_add(num, q_mul(pos, to_q32(frame_store[i])));
      end
      c = q_div(num, w);
      for (i = 0; i < n; i++) begin
        pos = int_div({32'd0, i} << 32, 64'(n - 1));
        v = q_sub(pos, c);
        v2 = q_mul(v, v);
        t = q_mul(v2, to_q32(frame_store[i]));
        m2 = q_add(m2, t);
        m3 = q_add(m3, q_mul(t, v));
        m4 = q_add(m4, q_mul(t, v2));
      end
      r32 = {16'd0, cfg_range, 16'd0};
      m2 = q_mul(q_mul(q_div(m2, w), r32), r32);
      m3 = q_mul(q_mul(q_mul(q_div(m3, w), r32), r32), r32);
      m4 = q_mul(q_mul(q_mul(q_mul(q_div(m4, w), r32), r32), r32), r32);
    end
    r.moment_zero = 1'b1;
    r.m2 = m2;
    r.m3 = m3;
    r.m4 = m4;
    return r;
  endfunction

  task automatic predict_sample(logic signed [15:0] s, logic last);
    if (frame_len < DEPTH) begin
      frame_store[frame_len] = s;
      frame_len++;
      frame_sum = q_add(frame_sum, to_q32(s));
    end
    if (last) begin
      expected_moments.push_back(close_frame());
      frame_len = 0;
      frame_sum = '0;
    end
  endtask

  // ---------------- drivers ----------------
  task automatic send_sample(logic signed [15:0] s, logic last);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_value <= s;
    in_last_sample <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_sample(s, last);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_PDF_MODE) cfg_pdf = data[0];
    else if (idx == REG_POS_RANGE) cfg_range = data;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_moments.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(logic pdf, logic [31:0] range);
    wait_idle();
    write_reg(REG_PDF_MODE, {31'd0, pdf});
    write_reg(REG_POS_RANGE, range);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return $signed(16'($urandom_range(255))) - 16'sd128;
      3: return 16'($urandom_range(32767));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_frame(int unsigned len, bit positive);
    logic signed [15:0] s;
    for (int unsigned k = 0; k < len; k++) begin
      s = rand_sample();
      if (positive && s < 0) s = -(s + 16'sd1);
      send_sample(s, k == len - 1);
    end
  endtask

  // ---------------- result checker and receiver ----------------
  always @(posedge clk) begin
    moments_t e;
    if (out_valid && !out_stall) begin
      if (expected_moments.size() == 0) begin
        $error("result transfer with no expectation pending");
        errors++;
      end else begin
        e = expected_moments.pop_front();
        if (out_status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_status);
          errors++;
        end
        if (out_moment_zero !== e.moment_zero) begin
          $error("moment_zero: expected %0d actual %0d", e.moment_zero, out_moment_zero);
          errors++;
        end
        if (out_moment_two !== e.m2) begin
          $error("moment_two: expected %h actual %h", e.m2, out_moment_two);
          errors++;
        end
        if (out_moment_three !== e.m3) begin
          $error("moment_three: expected %h actual %h", e.m3, out_moment_three);
          errors++;
        end
        if (out_moment_four !== e.m4) begin
          $error("moment_four: expected %h actual %h", e.m4, out_moment_four);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < rx_idle);
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= WD_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------- tests ----------------
  task automatic test_short_frames();
    send_sample(16'sh7FFF, 1'b1);
    set_config(1'b1, RANGE_RESET);
    send_sample(16'sh8000, 1'b1);
  endtask

  task automatic test_sample_extremes();
    set_config(1'b0, RANGE_RESET);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh8000, 1'b1);
    send_sample(16'sh0000, 1'b0);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh0001, 1'b1);
  endtask

  task automatic test_pdf_cases();
    set_config(1'b1, RANGE_RESET);
    send_sample(16'sh0100, 1'b0);   // weights cancel: zero weight sum
    send_sample(-16'sh0100, 1'b1);
    send_sample(16'sh7FFF, 1'b0);
    send_sample(16'sh4000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    set_config(1'b1, 32'hFFFF_FFFF);
    send_sample(16'sh0001, 1'b0);   // one negative weight, weights again sum to zero
    send_sample(16'sh8000, 1'b0);
    send_sample(16'sh7FFF, 1'b1);
    set_config(1'b1, 32'h0000_0000);
    send_sample(16'sh1234, 1'b0);
    send_sample(16'sh0F00, 1'b1);
    set_config(1'b0, 32'hDEAD_BEEF);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(8'($urandom_range(2, 254)), $urandom);
    send_sample(16'sh2000, 1'b0);
    send_sample(16'sh6000, 1'b1);
  endtask

  task automatic test_random(int unsigned items);
    int unsigned sent, len;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(3))
        0: set_config(1'b0, $urandom);
        1: set_config(1'b1, 32'($urandom_range(32'h3FFFF)));
        2: set_config(1'b1, $urandom_range(1) ? 32'hFFFF_FFFF : $urandom);
        default: set_config(1'($urandom_range(1)), RANGE_RESET);
      endcase
      for (int f = 0; f < 5; f++) begin
        case ($urandom_range(9))
          0: len = 1;
          1: len = $urandom_range(20, 64);
          default: len = $urandom_range(2, 10);
        endcase
        send_frame(len, cfg_pdf && $urandom_range(1));
        sent += len;
      end
    end
  endtask

  initial begin
    in_valid <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_short_frames();
    test_sample_extremes();
    test_pdf_cases();
    tx_idle = 13; rx_idle = 62;
    test_random(160);
    tx_idle = 62; rx_idle = 13;
    test_random(160);
    tx_idle = 0; rx_idle = 0;
    test_random(160);
    wait_idle();
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
